/* sv/utf8v_pkg.sv */
// shared constants, state type and per-byte step function of the utf-8 stream validator
package utf8v_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned TDATA_W = 8;

    // byte class boundaries
    localparam logic [7:0] ASCII_TOP = 8'h80;
    localparam logic [7:0] LEAD2_LO  = 8'hC0;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD_END  = 8'hF8;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // checker state carried across the words of one buffer
    typedef struct packed {
        logic [1:0] bytes_pending;
        logic       pending_bad;
        logic       verdict;
        logic       stopped;
    } utf8v_state_t;

    localparam utf8v_state_t STATE_CLEAR = '{
        bytes_pending: 2'd0, pending_bad: 1'b0, verdict: 1'b0, stopped: 1'b0};

    // state after one more byte of the buffer
    function automatic utf8v_state_t utf8v_step(utf8v_state_t s, logic [7:0] b);
        utf8v_state_t n;
        logic         bad_cont;
        n        = s;
        bad_cont = (b & CONT_MASK) != CONT_TAG;
        if (s.stopped) begin
            n = s;
        end else if (s.bytes_pending != 2'd0) begin
            // continuation byte: errors are held until the sequence closes
            n.pending_bad   = s.pending_bad | bad_cont;
            n.bytes_pending = s.bytes_pending - 2'd1;
            if (n.bytes_pending == 2'd0 && n.pending_bad) begin
                n.verdict = 1'b0;
                n.stopped = 1'b1;
            end
        end else begin
            n.pending_bad = 1'b0;
            if (b < ASCII_TOP) begin
                n.verdict = s.verdict;
            end else if (b < LEAD2_LO) begin
                n.verdict = 1'b0;
                n.stopped = 1'b1;
            end else if (b < LEAD3_LO) begin
                n.verdict       = 1'b1;
                n.bytes_pending = 2'd1;
            end else if (b < LEAD4_LO) begin
                n.verdict       = 1'b1;
                n.bytes_pending = 2'd2;
            end else if (b < LEAD_END) begin
                n.verdict       = 1'b1;
                n.bytes_pending = 2'd3;
            end else begin
                n.verdict = 1'b0;
                n.stopped = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

/* sv/utf8_stream_validator.sv */
// utf-8 stream validator: byte stream in, one verdict word per buffer out
//
// Bytes of a buffer arrive one per word on the s_ channel, the final byte
// flagged by s_tlast. One verdict word leaves on the m_ channel for every
// buffer: its final byte is taken into the input register, and from there
// the verdict is loaded into the result register.
// A new byte is accepted every clock while the result register is empty or
// being drained; m_tready low stalls both stages.
// Verdict bit is 1 when at least one multi-byte lead was seen and no error
// was found; a pure ascii buffer yields 0, and an unfinished trailing
// sequence is not checked.
module utf8_stream_validator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [utf8v_pkg::DATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                         s_tlast,   // last_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [utf8v_pkg::TDATA_W-1:0] m_tdata   // [0] is_utf8, [7:1] zero
);
    import utf8v_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_data_reg;
    logic         in_last_reg;
    utf8v_state_t state_reg;
    utf8v_state_t state_next;
    utf8v_state_t stepped;
    logic         out_valid_reg;
    logic         out_bit_reg;
    logic         advance;
    logic         consume;

    // pipeline moves whenever the result register can take a word
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign consume  = in_valid_reg && advance;

    // per-byte decision
    always_comb begin
        stepped    = utf8v_step(state_reg, in_data_reg);
        state_next = state_reg;
        if (consume) begin
            state_next = in_last_reg ? STATE_CLEAR : stepped;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // buffer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= consume && in_last_reg;
        end
        if (consume && in_last_reg) begin
            out_bit_reg <= stepped.verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-1){1'b0}}, out_bit_reg};

endmodule
